// ===== rtl/best_fit_heap_allocator_unit_macros.svh =====
// Assertion macros used by the allocator's controller.
`ifndef BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/bfa_pkg.sv =====
// Package with types, constants and codes of the heap allocator.
package bfa_pkg;
  localparam int HeapBytes = 65536;
  localparam int AlignBytes = 8;
  localparam int HeaderBytes = 16;
  localparam int MaxBlocks = 64;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int SizeW = 17;
  localparam int OfsW = 16;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_BADOFS = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  typedef struct packed {
    logic func;
    logic [16:0] want_bytes;
    logic [15:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] result_offset;
    logic [16:0] free_total;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_LAST, S_DECIDE, S_FSCAN, S_FSCAN_LAST,
    S_FDECIDE, S_MERGE, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_restart;
    logic scan_step;
    logic alloc_commit;
    logic free_commit;
    logic merge;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero;
    logic scan_end;
  } sts_t;
endpackage

// ===== rtl/best_fit_heap_allocator_unit.sv =====
// Top level: best-fit heap allocator with block coalescing.
// An allocate makes one pass, a free two passes, over the 64-entry block
// table; each pass reads the entries one by one through the read ports of
// the table RAMs, which share one read address.
// A new transaction is taken in the cycle after done; results cannot stall.
// Synchronous reset restores one free block spanning the heap.
module best_fit_heap_allocator_unit
  import bfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_int;

  bfa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .busy(busy), .cmd(cmd),
    .strobe(done));
  bfa_datapath u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp_int));

  assign rsp = rsp_int;
endmodule

// ===== rtl/bfa_ram.sv =====
// Generic single-port-write RAM with one registered read port.
module bfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bfa_datapath.sv =====
// Datapath: block table, scan registers, best-fit and neighbour search.
module bfa_datapath
  import bfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  cmd_t             cmd,
  output sts_t             sts,
  output rsp_t             rsp
);
  req_t                 cur;
  logic [MaxBlocks-1:0] valid;
  logic [MaxBlocks-1:0] used;
  logic [IdxW:0]        ridx;
  logic [IdxW-1:0]      cidx;
  logic                 cval;
  logic [OfsW-1:0]      st_rd;
  logic [SizeW-1:0]     sz_rd;
  logic [SizeW-1:0]     free_sum;
  logic [SizeW:0]       need;
  logic                 best_ok;
  logic [IdxW-1:0]      best;
  logic [OfsW-1:0]      best_start;
  logic [SizeW-1:0]     best_size;
  logic                 spare_ok;
  logic [IdxW-1:0]      spare;
  logic                 hit_ok;
  logic [IdxW-1:0]      hit;
  logic [OfsW-1:0]      hit_start;
  logic [SizeW-1:0]     hit_size;
  logic                 prev_ok;
  logic [IdxW-1:0]      prev;
  logic [SizeW-1:0]     prev_size;
  logic                 next_ok;
  logic [IdxW-1:0]      next;
  logic [SizeW-1:0]     next_size;
  logic [1:0]           status;
  logic [OfsW-1:0]      rofs;
  logic                 we_s;
  logic [IdxW-1:0]      wa_s;
  logic [OfsW-1:0]      wd_s;
  logic                 we_z;
  logic [IdxW-1:0]      wa_z;
  logic [SizeW-1:0]     wd_z;
  logic [1:0]           mstep;
  logic [SizeW:0]       rem;
  logic                 fits;
  logic                 better;
  logic [SizeW:0]       st_end;
  logic [SizeW:0]       hit_end;
  logic [SizeW-1:0]     merged;
  logic                 s0_fresh;
  logic                 z0_fresh;

  // Table entry zero holds the whole heap after reset; other stores are
  // defined by the valid bits.
  bfa_ram #(.Width(OfsW), .Depth(MaxBlocks)) u_start (
    .clk(clk), .we(we_s), .waddr(wa_s), .wdata(wd_s), .raddr(ridx[IdxW-1:0]),
    .rdata(st_rd));
  bfa_ram #(.Width(SizeW), .Depth(MaxBlocks)) u_size (
    .clk(clk), .we(we_z), .waddr(wa_z), .wdata(wd_z), .raddr(ridx[IdxW-1:0]),
    .rdata(sz_rd));

  logic [OfsW-1:0]  e_start;
  logic [SizeW-1:0] e_size;
  assign e_start = ((cidx == '0) && s0_fresh) ? '0 : st_rd;
  assign e_size  = ((cidx == '0) && z0_fresh) ? SizeW'(HeapBytes) : sz_rd;

  assign fits   = cval && valid[cidx] && !used[cidx] && ({1'b0, e_size} >= need);
  assign better = !best_ok || (e_size < best_size) ||
                  ((e_size == best_size) && (e_start < best_start));
  assign st_end  = {2'b0, e_start} + {1'b0, e_size};
  assign hit_end = {2'b0, hit_start} + {1'b0, hit_size};
  assign rem     = {1'b0, best_size} - need;
  assign merged  = (next_ok ? hit_size + next_size : hit_size);

  assign sts.is_free  = cur.func;
  assign sts.zero     = (cur.want_bytes == '0);
  assign sts.scan_end = ridx[IdxW];

  assign rsp.status        = status;
  assign rsp.result_offset = rofs;
  assign rsp.free_total    = free_sum;

  always_comb begin
    we_s = 1'b0; wa_s = spare; wd_s = '0;
    we_z = 1'b0; wa_z = best;  wd_z = '0;
    if (cmd.alloc_commit && (cur.want_bytes != '0) && best_ok && spare_ok &&
        (rem > (SizeW + 1)'(2 * HeaderBytes))) begin
      we_s = 1'b1; wa_s = spare; wd_s = best_start + OfsW'(need);
      we_z = 1'b1; wa_z = spare; wd_z = rem[SizeW-1:0];
    end
    if (cmd.merge) begin
      case (mstep)
        2'd0: begin
          we_z = 1'b1; wa_z = best; wd_z = need[SizeW-1:0];
        end
        2'd1: begin
          we_z = 1'b1;
          wa_z = prev_ok ? prev : hit;
          wd_z = prev_ok ? prev_size + merged : merged;
        end
        default: begin
          we_z = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= MaxBlocks'(1);
      used     <= '0;
      free_sum <= SizeW'(HeapBytes);
      ridx     <= '0;
      cval     <= 1'b0;
      mstep    <= '0;
      s0_fresh <= 1'b1;
      z0_fresh <= 1'b1;
    end else begin
      cval <= 1'b0;
      if (we_s && (wa_s == '0)) s0_fresh <= 1'b0;
      if (we_z && (wa_z == '0)) z0_fresh <= 1'b0;
      if (cmd.load) begin
        cur  <= req;
        need <= ((SizeW + 1)'(req.want_bytes) + (SizeW + 1)'(HeaderBytes + AlignBytes - 1))
                & ~(SizeW + 1)'(AlignBytes - 1);
      end
      if (cmd.scan_clear) begin
        ridx <= '0; best_ok <= 1'b0; spare_ok <= 1'b0; hit_ok <= 1'b0;
        prev_ok <= 1'b0; next_ok <= 1'b0;
        status <= ST_OK; rofs <= '0;
        mstep <= 2'd2;
      end
      if (cmd.scan_restart) begin
        ridx <= '0;
      end
      if (cmd.scan_step) begin
        if (!ridx[IdxW]) begin
          ridx <= ridx + 1'b1;
          cval <= 1'b1;
        end
        cidx <= ridx[IdxW-1:0];
        if (cval) begin
          if (!cur.func) begin
            if (!valid[cidx] && !spare_ok) begin
              spare_ok <= 1'b1; spare <= cidx;
            end
            if (fits && better) begin
              best_ok <= 1'b1; best <= cidx;
              best_start <= e_start; best_size <= e_size;
            end
          end else if (!hit_ok && valid[cidx] && used[cidx] &&
                       ({1'b0, e_start} + OfsW'(HeaderBytes) ==
                        {1'b0, cur.payload_offset})) begin
            hit_ok <= 1'b1; hit <= cidx; hit_start <= e_start; hit_size <= e_size;
          end
        end
      end
      if (cmd.alloc_commit) begin
        if (cur.want_bytes == '0) begin
          status <= ST_ZERO;
        end else if (!best_ok) begin
          status <= ST_NOFIT;
        end else begin
          used[best] <= 1'b1;
          rofs <= best_start + OfsW'(HeaderBytes);
          if (spare_ok && (rem > (SizeW + 1)'(2 * HeaderBytes))) begin
            valid[spare] <= 1'b1;
            used[spare]  <= 1'b0;
            free_sum     <= free_sum - need[SizeW-1:0];
            mstep        <= 2'd0;
          end else begin
            free_sum <= free_sum - best_size;
            need     <= {1'b0, best_size};
            mstep    <= 2'd0;
          end
        end
      end
      // The free path reuses the scan with the hit fixed, searching neighbours.
      if (cmd.scan_step && cur.func && hit_ok && cval &&
          valid[cidx] && !used[cidx] && (cidx != hit)) begin
        if (st_end == {2'b0, hit_start}) begin
          prev_ok <= 1'b1; prev <= cidx; prev_size <= e_size;
        end
        if (hit_end == {2'b0, e_start}) begin
          next_ok <= 1'b1; next <= cidx; next_size <= e_size;
        end
      end
      if (cmd.free_commit) begin
        if (!hit_ok) begin
          status <= ST_BADOFS;
        end else begin
          used[hit] <= 1'b0;
          free_sum  <= free_sum + hit_size;
          mstep     <= 2'd1;
        end
      end
      if (cmd.merge) begin
        if (mstep == 2'd1) begin
          if (next_ok) valid[next] <= 1'b0;
          if (prev_ok) valid[hit] <= 1'b0;
        end
        mstep <= 2'd2;
      end
    end
  end
endmodule

// ===== rtl/bfa_ctrl.sv =====
// Controller state machine sequencing the table scans and updates.
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd,
  output logic strobe
);
  `include "best_fit_heap_allocator_unit_macros.svh"
  state_t state, state_next;
  logic   second;
  logic   second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    second_next = second;
    cmd         = '0;
    busy        = (state != S_IDLE);
    strobe      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          cmd.scan_clear = 1'b1;
          second_next    = 1'b0;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) state_next = S_SCAN_LAST;
      end
      S_SCAN_LAST: begin
        cmd.scan_step = 1'b1;
        state_next    = sts.is_free ? S_FDECIDE : S_DECIDE;
      end
      S_DECIDE: begin
        cmd.alloc_commit = 1'b1;
        state_next       = S_MERGE;
      end
      S_FDECIDE: begin
        if (!second) begin
          cmd.scan_restart = 1'b1;
          second_next      = 1'b1;
          state_next       = S_FSCAN;
        end else begin
          cmd.free_commit = 1'b1;
          state_next      = S_MERGE;
        end
      end
      S_FSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) state_next = S_FSCAN_LAST;
      end
      S_FSCAN_LAST: begin
        cmd.scan_step = 1'b1;
        state_next    = S_FDECIDE;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        strobe     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BFA_ASSERT_NEXT(a_start_busy, clk, rst, (state == S_IDLE) && start, busy, "no busy")
  `BFA_ASSERT_IMP(a_strobe_busy, clk, rst, strobe, busy, "strobe while idle")
  `BFA_ASSERT_NEXT(a_strobe_idle, clk, rst, strobe, !busy, "busy after strobe")
endmodule
